[design/mst_pkg.sv]
package mst_pkg;

	localparam int SLOT_COUNT_DEF = 5;
	localparam int COORD_W        = 12;
	localparam int DIM_W          = 13;
	localparam int SLOT_W         = 4;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd800;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;
	localparam logic [DIM_W-1:0] DIM_MAX      = 13'd4096;

	localparam logic [2:0] CMD_SELECT = 3'd0;
	localparam logic [2:0] CMD_ABS_X  = 3'd1;
	localparam logic [2:0] CMD_ABS_Y  = 3'd2;
	localparam logic [2:0] CMD_KEY    = 3'd3;
	localparam logic [2:0] CMD_TICK   = 3'd4;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	typedef struct packed {
		logic [2:0]         command;
		logic signed [31:0] event_value;
	} in_item_t;

	typedef struct packed {
		logic [SLOT_W-1:0]  slot_index;
		logic               touching;
		logic [COORD_W-1:0] x_pos;
		logic [COORD_W-1:0] y_pos;
		logic               last_in_report;
	} out_item_t;

	typedef struct packed {
		logic               down;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} slot_entry_t;

endpackage

[design/mst_ram.sv]
module mst_ram #(
	parameter int WIDTH = 25,
	parameter int DEPTH = 5,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[design/multitouch_slot_tracker.sv]
// Select and ignored commands leave the tracker idle, ready for a new item straight after.
// X, Y and key items: a read-modify-write of the slot RAM, with in_stall high during the write-back.
// Report tick: one item per dirty slot, lowest slot first, held back while out_stall holds;
// each slot is read from the RAM and then registered into out_data in the emit state.
// Reset (arst_n low): screen size 800x480, active slot 0, all slots clean and read as zero.
module multitouch_slot_tracker #(
	parameter int SLOT_COUNT = mst_pkg::SLOT_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  mst_pkg::in_item_t              in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output mst_pkg::out_item_t             out_data,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [mst_pkg::DIM_W-1:0]      cfg_data
);

	localparam int IDX_W   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int ENTRY_W = $bits(mst_pkg::slot_entry_t);
	localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(SLOT_COUNT - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_EMIT
	} state_t;

	function automatic logic [IDX_W-1:0] low_idx(input logic [SLOT_COUNT-1:0] m);
		logic [IDX_W-1:0] r;
		r = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (m[i]) begin
				r = IDX_W'(i);
			end
		end
		return r;
	endfunction

	function automatic logic [mst_pkg::COORD_W-1:0] clamp_coord(
		input logic signed [31:0]          v,
		input logic [mst_pkg::DIM_W-1:0]   dim
	);
		logic [mst_pkg::DIM_W-1:0]   d;
		logic [mst_pkg::COORD_W-1:0] hi;
		logic [mst_pkg::COORD_W-1:0] r;
		d = dim;
		if (d == '0) begin
			d = mst_pkg::DIM_W'(1);
		end else if (d > mst_pkg::DIM_MAX) begin
			d = mst_pkg::DIM_MAX;
		end
		hi = mst_pkg::COORD_W'(d - mst_pkg::DIM_W'(1));
		if (v[31]) begin
			r = '0;
		end else if (v[30:mst_pkg::COORD_W] != '0 || v[mst_pkg::COORD_W-1:0] > hi) begin
			r = hi;
		end else begin
			r = v[mst_pkg::COORD_W-1:0];
		end
		return r;
	endfunction

	state_t                       state_q;
	logic [mst_pkg::DIM_W-1:0]    width_q;
	logic [mst_pkg::DIM_W-1:0]    height_q;
	logic [IDX_W-1:0]             active_q;
	logic [IDX_W-1:0]             addr_q;
	logic [IDX_W-1:0]             ptr_q;
	logic [2:0]                   op_q;
	logic [mst_pkg::COORD_W-1:0]  coord_q;
	logic                         pressed_q;
	logic [SLOT_COUNT-1:0]        dirty_q;
	logic [SLOT_COUNT-1:0]        written_q;
	logic                         rd_ok_q;
	logic                         out_valid_q;
	mst_pkg::out_item_t           out_q;

	logic                         in_fire;
	logic                         emit;
	logic                         more;
	logic [SLOT_COUNT-1:0]        above;
	logic [IDX_W-1:0]             next_idx;
	logic                         re;
	logic [IDX_W-1:0]             raddr;
	logic                         we;
	logic [ENTRY_W-1:0]           rdata;
	mst_pkg::slot_entry_t         cur;
	mst_pkg::slot_entry_t         upd;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign cur  = rd_ok_q ? mst_pkg::slot_entry_t'(rdata) : '0;
	assign emit = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	always_comb begin
		for (int i = 0; i < SLOT_COUNT; i++) begin
			above[i] = dirty_q[i] && (IDX_W'(i) > ptr_q);
		end
	end
	assign more     = |above;
	assign next_idx = low_idx(above);

	always_comb begin
		upd = cur;
		we  = 1'b0;
		if (state_q == ST_UPDATE) begin
			unique case (op_q)
				mst_pkg::CMD_ABS_X: begin
					upd.x = coord_q;
					we    = 1'b1;
				end
				mst_pkg::CMD_ABS_Y: begin
					upd.y = coord_q;
					we    = 1'b1;
				end
				default: begin
					upd.down = pressed_q;
					we       = (cur.down != pressed_q);
				end
			endcase
		end
	end

	always_comb begin
		re    = 1'b0;
		raddr = active_q;
		if (in_fire) begin
			priority if (in_data.command == mst_pkg::CMD_ABS_X ||
			             in_data.command == mst_pkg::CMD_ABS_Y ||
			             in_data.command == mst_pkg::CMD_KEY) begin
				re = 1'b1;
			end else if (in_data.command == mst_pkg::CMD_TICK) begin
				re    = |dirty_q;
				raddr = low_idx(dirty_q);
			end else begin
				re = 1'b0;
			end
		end else if (emit && more) begin
			re    = 1'b1;
			raddr = next_idx;
		end
	end

	mst_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SLOT_COUNT)
	) u_slot_ram (
		.clk   (clk),
		.we    (we),
		.waddr (addr_q),
		.wdata (upd),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= mst_pkg::WIDTH_RESET;
			height_q <= mst_pkg::HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mst_pkg::CFG_WIDTH:  width_q  <= cfg_data;
				mst_pkg::CFG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_ok_q <= written_q[raddr];
		end
		if (in_fire) begin
			op_q      <= in_data.command;
			addr_q    <= active_q;
			pressed_q <= (in_data.event_value != '0);
			coord_q   <= clamp_coord(in_data.event_value,
				(in_data.command == mst_pkg::CMD_ABS_Y) ? height_q : width_q);
		end
		if (emit) begin
			out_q.slot_index     <= mst_pkg::SLOT_W'(ptr_q);
			out_q.touching       <= cur.down;
			out_q.x_pos          <= cur.x;
			out_q.y_pos          <= cur.y;
			out_q.last_in_report <= !more;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			active_q    <= '0;
			ptr_q       <= '0;
			dirty_q     <= '0;
			written_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (we) begin
				written_q[addr_q] <= 1'b1;
				dirty_q[addr_q]   <= 1'b1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						priority if (in_data.command == mst_pkg::CMD_SELECT) begin
							if (in_data.event_value[31]) begin
								active_q <= '0;
							end else if (in_data.event_value > $signed(32'(SLOT_COUNT - 1))) begin
								active_q <= IDX_MAX;
							end else begin
								active_q <= IDX_W'(in_data.event_value);
							end
						end else if (in_data.command == mst_pkg::CMD_TICK) begin
							if (|dirty_q) begin
								ptr_q   <= low_idx(dirty_q);
								state_q <= ST_EMIT;
							end
						end else if (in_data.command == mst_pkg::CMD_ABS_X ||
						             in_data.command == mst_pkg::CMD_ABS_Y ||
						             in_data.command == mst_pkg::CMD_KEY) begin
							state_q <= ST_UPDATE;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_UPDATE: begin
					state_q <= ST_IDLE;
				end
				ST_EMIT: begin
					if (emit) begin
						dirty_q[ptr_q] <= 1'b0;
						if (more) begin
							ptr_q <= next_idx;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_emit_dirty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> dirty_q[ptr_q])
		else $error("scan points at a clean slot");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> !dirty_q[$past(ptr_q)])
		else $error("reported slot still dirty");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && !more) |=> (state_q == ST_IDLE && out_valid_q && out_q.last_in_report))
		else $error("final item does not end the scan");

	a_active_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q <= IDX_MAX)
		else $error("active slot out of range");

	a_write_idle_out: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> state_q == ST_UPDATE && !emit)
		else $error("slot write outside update");

endmodule
